// File: rtl/gbc_pkg.sv
// ----------------------------------------------------------------------------
// gbc_pkg
// Shared types, constants and constant tables for the gamma and brightness
// correction block.
// ----------------------------------------------------------------------------
package gbc_pkg;

    localparam int FRAC_BITS    = 30;
    localparam int LEVEL_W      = 8;
    localparam int GAMMA_W      = 16;
    localparam int OFFSET_W     = 8;
    localparam int OUT_W        = 16;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 16;
    localparam int D_W          = 33;   // log2 difference, Q30, below 8.0
    localparam int DEN_W        = 19;   // 5 * gamma
    localparam int NUM_W        = 47;   // D * 8192 + den / 2
    localparam int QUO_W        = 36;   // attenuation exponent T, Q30
    localparam int REM_W        = 19;
    localparam int N_W          = QUO_W - FRAC_BITS;
    localparam int Y_W          = FRAC_BITS + 1;
    localparam int LEVEL_MAX    = 255;
    localparam int GAMMA_FLOOR  = 410;
    localparam int OFFSET_LIMIT = 50;
    localparam int GAMMA_RESET  = 1638;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RED_GAMMA    = 8'd0,
        REG_GREEN_GAMMA  = 8'd1,
        REG_BLUE_GAMMA   = 8'd2,
        REG_LEVEL_OFFSET = 8'd3
    } gbc_reg_idx_t;

    // pipeline control shared by all lanes
    typedef struct packed {
        logic advance;
        logic load;
    } gbc_lane_ctrl_t;

    typedef logic [D_W-1:0] d_table_t [256];
    typedef logic [Y_W-1:0] exp_rom_t [FRAC_BITS+1];

    // integer square root, evaluated at elaboration only
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] rem;
        logic [63:0] bit_w;
        res   = '0;
        rem   = v;
        bit_w = 64'h4000_0000_0000_0000;
        for (int j = 0; j < 32; j++) begin
            if (rem >= res + bit_w) begin
                rem = rem - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    // 2^-(2^-i) in Q30 for i >= 1; entry 0 holds 1.0
    function automatic exp_rom_t build_exp_rom();
        exp_rom_t    rom;
        logic [63:0] c;
        rom[0] = Y_W'(64'd1 << FRAC_BITS);
        c = isqrt64(64'd1 << 59);
        rom[1] = Y_W'(c);
        for (int i = 2; i <= FRAC_BITS; i++) begin
            c = isqrt64(c << FRAC_BITS);
            rom[i] = Y_W'(c);
        end
        return rom;
    endfunction

    // log2 of 1..255 in Q30 by repeated squaring
    function automatic logic [63:0] log2_q(input int v);
        int          k;
        logic [63:0] x;
        logic [63:0] frac;
        k    = 0;
        frac = '0;
        for (int b = 1; b < 8; b++) begin
            if ((v >> b) != 0) k = b;
        end
        x = 64'(v) << (FRAC_BITS - k);
        for (int i = 0; i < FRAC_BITS; i++) begin
            x    = (x * x) >> FRAC_BITS;
            frac = frac << 1;
            if (x >= (64'd2 << FRAC_BITS)) begin
                x    = x >> 1;
                frac = frac | 64'd1;
            end
        end
        return (64'(k) << FRAC_BITS) | frac;
    endfunction

    // log2(255) - log2(level), level zero handled separately
    function automatic d_table_t build_d_table();
        d_table_t    tab;
        logic [63:0] top;
        top    = log2_q(LEVEL_MAX);
        tab[0] = '0;
        for (int v = 1; v < 256; v++) begin
            tab[v] = D_W'(top - log2_q(v));
        end
        return tab;
    endfunction

    localparam d_table_t D_TABLE = build_d_table();
    localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

// File: rtl/gamma_brightness_correction.sv
// ----------------------------------------------------------------------------
// gamma_brightness_correction
// Per-pixel brightness offset and power-law gamma correction, 8-bit RGB in,
// 16-bit RGB out, three channel lanes in parallel.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one corrected pixel per clock while
// the result channel accepts them. A pixel passes the lane stages (level
// capture, numerator, restoring divider: 36 stages, one quotient bit each;
// exp2 chain: 30 stages, one constant multiply each; shift; scaling), then
// the output register. A skid register keeps one more transaction while the
// result channel stalls; s_ready drops only when that register is full.
// Registers: 0 red gamma, 1 green gamma, 2 blue gamma (unsigned Q4.12,
// floored to 410), 3 level offset (signed, clamped to -50..50). Write them
// only while no transaction is in flight.
module gamma_brightness_correction (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [gbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gbc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [gbc_pkg::LEVEL_W-1:0]     s_red_in,
    input  logic [gbc_pkg::LEVEL_W-1:0]     s_green_in,
    input  logic [gbc_pkg::LEVEL_W-1:0]     s_blue_in,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [gbc_pkg::OUT_W-1:0]       m_red_out,
    output logic [gbc_pkg::OUT_W-1:0]       m_green_out,
    output logic [gbc_pkg::OUT_W-1:0]       m_blue_out
);

    logic [gbc_pkg::GAMMA_W-1:0]  red_gamma_reg;
    logic [gbc_pkg::GAMMA_W-1:0]  green_gamma_reg;
    logic [gbc_pkg::GAMMA_W-1:0]  blue_gamma_reg;
    logic [gbc_pkg::OFFSET_W-1:0] offset_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_gamma_reg   <= gbc_pkg::GAMMA_W'(gbc_pkg::GAMMA_RESET);
            green_gamma_reg <= gbc_pkg::GAMMA_W'(gbc_pkg::GAMMA_RESET);
            blue_gamma_reg  <= gbc_pkg::GAMMA_W'(gbc_pkg::GAMMA_RESET);
            offset_reg      <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                gbc_pkg::REG_RED_GAMMA:    red_gamma_reg   <= cfg_wdata;
                gbc_pkg::REG_GREEN_GAMMA:  green_gamma_reg <= cfg_wdata;
                gbc_pkg::REG_BLUE_GAMMA:   blue_gamma_reg  <= cfg_wdata;
                gbc_pkg::REG_LEVEL_OFFSET:
                    offset_reg <= cfg_wdata[gbc_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // offset clamp
    logic signed [gbc_pkg::OFFSET_W-1:0] off_s;
    logic signed [gbc_pkg::OFFSET_W-1:0] off_c;
    assign off_s = $signed(offset_reg);
    assign off_c = (off_s < -gbc_pkg::OFFSET_W'(gbc_pkg::OFFSET_LIMIT))
                 ? -gbc_pkg::OFFSET_W'(gbc_pkg::OFFSET_LIMIT)
                 : (off_s > gbc_pkg::OFFSET_W'(gbc_pkg::OFFSET_LIMIT))
                 ? gbc_pkg::OFFSET_W'(gbc_pkg::OFFSET_LIMIT) : off_s;

    // level plus offset, clamped to 0..255
    function automatic logic [gbc_pkg::LEVEL_W-1:0] add_clamp(
        input logic [gbc_pkg::LEVEL_W-1:0]        lv,
        input logic signed [gbc_pkg::OFFSET_W-1:0] off
    );
        logic signed [gbc_pkg::LEVEL_W+1:0] s;
        s = $signed({2'b00, lv}) + (gbc_pkg::LEVEL_W+2)'(off);
        if (s < 0) return '0;
        if (s > (gbc_pkg::LEVEL_W+2)'(gbc_pkg::LEVEL_MAX)) return '1;
        return s[gbc_pkg::LEVEL_W-1:0];
    endfunction

    gbc_pkg::gbc_lane_ctrl_t      ctrl;
    logic                         advance;
    logic [2:0]                   lane_valid;
    logic [gbc_pkg::OUT_W-1:0]    red_res;
    logic [gbc_pkg::OUT_W-1:0]    green_res;
    logic [gbc_pkg::OUT_W-1:0]    blue_res;

    assign s_ready      = advance;
    assign ctrl.advance = advance;
    assign ctrl.load    = s_valid;

    gbc_lane u_lane_red (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .level      (add_clamp(s_red_in, off_c)),
        .gamma      (red_gamma_reg),
        .lane_valid (lane_valid[0]),
        .lane_out   (red_res)
    );

    gbc_lane u_lane_green (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .level      (add_clamp(s_green_in, off_c)),
        .gamma      (green_gamma_reg),
        .lane_valid (lane_valid[1]),
        .lane_out   (green_res)
    );

    gbc_lane u_lane_blue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .level      (add_clamp(s_blue_in, off_c)),
        .gamma      (blue_gamma_reg),
        .lane_valid (lane_valid[2]),
        .lane_out   (blue_res)
    );

    gbc_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .lane_valid  (lane_valid),
        .red_res     (red_res),
        .green_res   (green_res),
        .blue_res    (blue_res),
        .advance     (advance),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out)
    );

endmodule

// File: rtl/gbc_lane.sv
// ----------------------------------------------------------------------------
// gbc_lane
// One color channel: log lookup, pipelined divide by 2.5*gamma, exp2 by
// constant multiplies, and final scaling to 16 bits.
// ----------------------------------------------------------------------------
module gbc_lane (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  gbc_pkg::gbc_lane_ctrl_t        ctrl,
    input  logic [gbc_pkg::LEVEL_W-1:0]    level,
    input  logic [gbc_pkg::GAMMA_W-1:0]    gamma,
    output logic                           lane_valid,
    output logic [gbc_pkg::OUT_W-1:0]      lane_out
);

    localparam int DIV_N = gbc_pkg::QUO_W;
    localparam int EXP_N = gbc_pkg::FRAC_BITS;

    // divisor from the gamma register, floored
    logic [gbc_pkg::GAMMA_W-1:0] gamma_f;
    logic [gbc_pkg::DEN_W-1:0]   den;
    assign gamma_f = (gamma < gbc_pkg::GAMMA_W'(gbc_pkg::GAMMA_FLOOR))
                   ? gbc_pkg::GAMMA_W'(gbc_pkg::GAMMA_FLOOR) : gamma;
    assign den = {3'b000, gamma_f} + {1'b0, gamma_f, 2'b00};

    // stage 0: level capture
    logic                        v0_reg;
    logic [gbc_pkg::LEVEL_W-1:0] lvl0_reg;

    // stage 1: numerator
    logic                        v1_reg;
    logic                        z1_reg;
    logic [gbc_pkg::NUM_W-1:0]   num1_reg;
    logic [gbc_pkg::NUM_W-1:0]   num1_next;

    assign num1_next = {1'b0, gbc_pkg::D_TABLE[lvl0_reg], 13'd0}
                     + gbc_pkg::NUM_W'(den >> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else if (ctrl.advance) begin
            v0_reg <= ctrl.load;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            lvl0_reg <= level;
            num1_reg <= num1_next;
            z1_reg   <= (lvl0_reg == '0);
        end
    end

    // divider stages, one quotient bit each
    logic                        dv_reg  [DIV_N+1];
    logic                        dz_reg  [DIV_N+1];
    logic [gbc_pkg::NUM_W-1:0]   dn_reg  [DIV_N+1];
    logic [gbc_pkg::REM_W-1:0]   dr_reg  [DIV_N+1];
    logic [gbc_pkg::QUO_W-1:0]   dq_reg  [DIV_N+1];

    assign dv_reg[0] = v1_reg;
    assign dz_reg[0] = z1_reg;
    assign dn_reg[0] = num1_reg;
    assign dr_reg[0] = gbc_pkg::REM_W'(num1_reg[gbc_pkg::NUM_W-1:DIV_N]);
    assign dq_reg[0] = '0;

    for (genvar k = 0; k < DIV_N; k++) begin : g_div
        logic [gbc_pkg::REM_W:0]   r2;
        logic                      ge;
        logic [gbc_pkg::REM_W-1:0] rem_next;
        assign r2 = {dr_reg[k], dn_reg[k][DIV_N-1-k]};
        assign ge = (r2 >= {1'b0, den});
        assign rem_next = ge ? gbc_pkg::REM_W'(r2 - {1'b0, den})
                             : gbc_pkg::REM_W'(r2);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k+1] <= 1'b0;
            end else if (ctrl.advance) begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (ctrl.advance) begin
                dz_reg[k+1] <= dz_reg[k];
                dn_reg[k+1] <= dn_reg[k];
                dr_reg[k+1] <= rem_next;
                dq_reg[k+1] <= dq_reg[k] | (gbc_pkg::QUO_W'(ge) << (DIV_N-1-k));
            end
        end
    end

    // exp2 stages, one fraction bit each
    logic                      ev_reg [EXP_N+1];
    logic                      ek_reg [EXP_N+1];
    logic [gbc_pkg::QUO_W-1:0] et_reg [EXP_N+1];
    logic [gbc_pkg::Y_W-1:0]   ey_reg [EXP_N+1];

    assign ev_reg[0] = dv_reg[DIV_N];
    assign ek_reg[0] = dz_reg[DIV_N]
        || (dq_reg[DIV_N][gbc_pkg::QUO_W-1:gbc_pkg::FRAC_BITS]
            > gbc_pkg::N_W'(gbc_pkg::FRAC_BITS));
    assign et_reg[0] = dq_reg[DIV_N];
    assign ey_reg[0] = gbc_pkg::EXP_ROM[0];

    for (genvar i = 1; i <= EXP_N; i++) begin : g_exp
        logic [2*gbc_pkg::Y_W-1:0] prod;
        logic [gbc_pkg::Y_W-1:0]   y_next;
        assign prod   = ey_reg[i-1] * gbc_pkg::EXP_ROM[i];
        assign y_next = et_reg[i-1][gbc_pkg::FRAC_BITS-i]
                      ? prod[gbc_pkg::FRAC_BITS +: gbc_pkg::Y_W] : ey_reg[i-1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ev_reg[i] <= 1'b0;
            end else if (ctrl.advance) begin
                ev_reg[i] <= ev_reg[i-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (ctrl.advance) begin
                ek_reg[i] <= ek_reg[i-1];
                et_reg[i] <= et_reg[i-1];
                ey_reg[i] <= y_next;
            end
        end
    end

    // integer shift, then scale to 16 bits with round half up
    logic                      sv_reg;
    logic [gbc_pkg::Y_W-1:0]   ys_reg;
    logic                      ov_reg;
    logic [gbc_pkg::OUT_W-1:0] out_reg;
    logic [47:0]               scaled;

    assign scaled = 48'(ys_reg) * 48'(16'hFFFF) + (48'd1 << (gbc_pkg::FRAC_BITS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else if (ctrl.advance) begin
            sv_reg <= ev_reg[EXP_N];
            ov_reg <= sv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            ys_reg  <= ek_reg[EXP_N] ? '0
                     : ey_reg[EXP_N] >> et_reg[EXP_N][gbc_pkg::QUO_W-1:gbc_pkg::FRAC_BITS];
            out_reg <= scaled[gbc_pkg::FRAC_BITS +: gbc_pkg::OUT_W];
        end
    end

    assign lane_valid = ov_reg;
    assign lane_out   = out_reg;

endmodule

// File: rtl/gbc_out.sv
// ----------------------------------------------------------------------------
// gbc_out
// Merges the three lane results into one transaction, with an output
// register and a skid register toward the result channel.
// ----------------------------------------------------------------------------
module gbc_out (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [2:0]                 lane_valid,
    input  logic [gbc_pkg::OUT_W-1:0]  red_res,
    input  logic [gbc_pkg::OUT_W-1:0]  green_res,
    input  logic [gbc_pkg::OUT_W-1:0]  blue_res,
    output logic                       advance,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [gbc_pkg::OUT_W-1:0]  m_red_out,
    output logic [gbc_pkg::OUT_W-1:0]  m_green_out,
    output logic [gbc_pkg::OUT_W-1:0]  m_blue_out
);

    logic                      out_valid_reg;
    logic                      skid_valid_reg;
    logic [3*gbc_pkg::OUT_W-1:0] out_data_reg;
    logic [3*gbc_pkg::OUT_W-1:0] skid_data_reg;
    logic                      in_valid;
    logic                      out_free;

    // lanes run in lock step
    assign in_valid = &lane_valid;
    assign advance  = !skid_valid_reg;
    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (m_ready) begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (in_valid) begin
                if (out_free) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload moves
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (in_valid) begin
            if (out_free) begin
                out_data_reg <= {red_res, green_res, blue_res};
            end else begin
                skid_data_reg <= {red_res, green_res, blue_res};
            end
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_red_out   = out_data_reg[3*gbc_pkg::OUT_W-1:2*gbc_pkg::OUT_W];
    assign m_green_out = out_data_reg[2*gbc_pkg::OUT_W-1:gbc_pkg::OUT_W];
    assign m_blue_out  = out_data_reg[gbc_pkg::OUT_W-1:0];

endmodule

// File: rtl/gbc_checker.sv
// ----------------------------------------------------------------------------
// gbc_checker
// Port-level checks on the result channel and input flow control.
// ----------------------------------------------------------------------------
module gbc_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_ready,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [gbc_pkg::OUT_W-1:0]  m_red_out
);

    // nothing is presented right after reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an empty output side never blocks input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // input stalls only behind a waiting result
    a_stall_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled without pending result");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red_out))
        else $error("result dropped or changed while stalled");

endmodule

bind gamma_brightness_correction gbc_checker u_gbc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_red_out (m_red_out)
);

// File: tb/gamma_brightness_correction_tb.sv
// ----------------------------------------------------------------------------
// gamma_brightness_correction_tb
// Self-checking bench for the gamma and brightness correction block. Pixels
// are streamed with random gaps and back-pressure. A bit-exact fixed-point
// predictor, kept in a scoreboard, forms the expected levels of each accepted
// pixel. Every returned pixel is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module gamma_brightness_correction_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          Q            = 30;
    localparam int          DRAIN_CYCLES = 100;
    localparam int          STALL_LIMIT  = 20000;
    localparam int          RANDOM_ITEMS = 1900;
    localparam int          PHASES       = 10;
    localparam logic [7:0]  REG_UNUSED   = 8'd200;

    typedef struct {
        bit [15:0] red;
        bit [15:0] green;
        bit [15:0] blue;
    } rgb16_t;

    // expected-pixel store plus bit-exact correction predictor
    class pixel_scoreboard;
        bit [15:0]       gamma_q [3];
        bit signed [7:0] offset_raw;
        bit [63:0]       pow_rom [Q+1];
        rgb16_t          expected_q [$];
        bit              failed;

        function new();
            gamma_q    = '{16'd1638, 16'd1638, 16'd1638};
            offset_raw = 0;
            failed     = 0;
            pow_rom[0] = 64'd1 << Q;
            pow_rom[1] = sqrt_floor(64'd1 << 59);
            for (int i = 2; i <= Q; i++) pow_rom[i] = sqrt_floor(pow_rom[i-1] << Q);
        endfunction

        function bit [63:0] sqrt_floor(bit [63:0] v);
            bit [63:0] root, probe;
            root  = 0;
            probe = 64'd1 << 62;
            for (int j = 0; j < 32; j++) begin
                if (v >= root + probe) begin
                    v    = v - (root + probe);
                    root = (root >> 1) + probe;
                end else begin
                    root = root >> 1;
                end
                probe = probe >> 2;
            end
            return root;
        endfunction

        // log2 of 1..255 in Q30, fraction by repeated squaring
        function bit [63:0] log2_fix(int unsigned v);
            int unsigned msb;
            bit [63:0]   x, frac;
            msb  = 0;
            frac = 0;
            while (msb < 7 && (v >> (msb + 1)) != 0) msb++;
            x = 64'(v) << (Q - msb);
            for (int i = 0; i < Q; i++) begin
                x    = (x * x) >> Q;
                frac = frac << 1;
                if (x >= (64'd2 << Q)) begin
                    x    = x >> 1;
                    frac = frac | 1;
                end
            end
            return (64'(msb) << Q) | frac;
        endfunction

        function bit [15:0] correct_channel(int lvl, bit [15:0] g);
            bit [63:0] diff, den, atten, y;
            int unsigned whole;
            if (lvl == 0) return 0;
            if (g < gbc_pkg::GAMMA_FLOOR) g = gbc_pkg::GAMMA_FLOOR;
            diff  = log2_fix(gbc_pkg::LEVEL_MAX) - log2_fix(lvl);
            den   = 5 * 64'(g);
            atten = (diff * 8192 + den / 2) / den;
            whole = atten >> Q;
            if (whole > Q) return 0;
            y = 64'd1 << Q;
            for (int i = 1; i <= Q; i++)
                if (atten[Q-i]) y = (y * pow_rom[i]) >> Q;
            y = y >> whole;
            return 16'((y * 65535 + (64'd1 << (Q - 1))) >> Q);
        endfunction

        function void write_reg(bit [7:0] idx, bit [15:0] data);
            case (idx)
                gbc_pkg::REG_RED_GAMMA:    gamma_q[0] = data;
                gbc_pkg::REG_GREEN_GAMMA:  gamma_q[1] = data;
                gbc_pkg::REG_BLUE_GAMMA:   gamma_q[2] = data;
                gbc_pkg::REG_LEVEL_OFFSET: offset_raw = data[7:0];
                default: ;
            endcase
        endfunction

        function int apply_offset(bit [7:0] lvl);
            int off, sum;
            off = offset_raw;
            if (off < -gbc_pkg::OFFSET_LIMIT) off = -gbc_pkg::OFFSET_LIMIT;
            if (off > gbc_pkg::OFFSET_LIMIT) off = gbc_pkg::OFFSET_LIMIT;
            sum = int'(lvl) + off;
            if (sum < 0) sum = 0;
            if (sum > gbc_pkg::LEVEL_MAX) sum = gbc_pkg::LEVEL_MAX;
            return sum;
        endfunction

        function void note_pixel(bit [7:0] r, bit [7:0] g, bit [7:0] b);
            rgb16_t e;
            e.red   = correct_channel(apply_offset(r), gamma_q[0]);
            e.green = correct_channel(apply_offset(g), gamma_q[1]);
            e.blue  = correct_channel(apply_offset(b), gamma_q[2]);
            expected_q.push_back(e);
        endfunction

        function void check_pixel(bit [15:0] r, bit [15:0] g, bit [15:0] b);
            rgb16_t e;
            if (expected_q.size() == 0) begin
                $display("%t: unexpected result %h %h %h", $realtime, r, g, b);
                failed = 1;
                return;
            end
            e = expected_q.pop_front();
            if (e.red !== r) begin
                $display("%t: red expected %h actual %h", $realtime, e.red, r);
                failed = 1;
            end
            if (e.green !== g) begin
                $display("%t: green expected %h actual %h", $realtime, e.green, g);
                failed = 1;
            end
            if (e.blue !== b) begin
                $display("%t: blue expected %h actual %h", $realtime, e.blue, b);
                failed = 1;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [7:0]  cfg_index = 0;
    logic [15:0] cfg_wdata = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [7:0]  s_red_in = 0, s_green_in = 0, s_blue_in = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [15:0] m_red_out, m_green_out, m_blue_out;
    bit          no_idle = 0;
    int          stall_cycles = 0;
    pixel_scoreboard sb = new();

    gamma_brightness_correction dut (.*);

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    // sink back-pressure
    always @(posedge aclk) m_ready <= no_idle || ($urandom_range(99) >= 13);

    // transaction monitor and stall watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_pixel(s_red_in, s_green_in, s_blue_in);
            if (m_valid && m_ready) sb.check_pixel(m_red_out, m_green_out, m_blue_out);
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send_pixel(bit [7:0] r, bit [7:0] g, bit [7:0] b);
        while (!no_idle && $urandom_range(99) < 13) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid    <= 1;
        s_red_in   <= r;
        s_green_in <= g;
        s_blue_in  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stop the stream and let the pipeline empty out
    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(bit [7:0] idx, bit [15:0] data);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_wdata <= data;
        sb.write_reg(idx, data);
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    task automatic write_all(bit [15:0] rg, bit [15:0] gg, bit [15:0] bg, bit [7:0] off);
        write_reg(gbc_pkg::REG_RED_GAMMA, rg);
        write_reg(gbc_pkg::REG_GREEN_GAMMA, gg);
        write_reg(gbc_pkg::REG_BLUE_GAMMA, bg);
        write_reg(gbc_pkg::REG_LEVEL_OFFSET, {8'd0, off});
    endtask

    function automatic bit [15:0] pick_gamma();
        case ($urandom_range(5))
            0: return 16'($urandom_range(409));
            1: return 16'hffff;
            2: return 16'($urandom_range(410, 4096));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic bit [7:0] pick_level();
        case ($urandom_range(7))
            0: return 8'($urandom_range(3));
            1: return 8'($urandom_range(252, 255));
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // reset settings: level extremes and mid values
        send_pixel(8'd0, 8'd255, 8'd1);
        send_pixel(8'd255, 8'd0, 8'd128);
        send_pixel(8'd254, 8'd2, 8'd85);
        drain();

        // small gamma floor and deep attenuation, unused index ignored
        write_all(16'd0, 16'd409, 16'd410, 8'd0);
        write_reg(REG_UNUSED, 16'hffff);
        send_pixel(8'd1, 8'd1, 8'd1);
        send_pixel(8'd2, 8'd3, 8'd4);
        send_pixel(8'd255, 8'd128, 8'd0);
        drain();

        // large gamma, offset clamped high
        write_all(16'hffff, 16'h8000, 16'd4096, 8'd127);
        send_pixel(8'd0, 8'd204, 8'd205);
        send_pixel(8'd1, 8'd255, 8'd100);
        drain();

        // offset clamped low, exact limits
        write_all(16'd1638, 16'd2048, 16'd8192, 8'h80);
        send_pixel(8'd50, 8'd51, 8'd49);
        send_pixel(8'd255, 8'd0, 8'd128);
        drain();
        write_reg(gbc_pkg::REG_LEVEL_OFFSET, 16'(-50));
        send_pixel(8'd50, 8'd51, 8'd255);
        drain();
        write_reg(gbc_pkg::REG_LEVEL_OFFSET, 16'd50);
        send_pixel(8'd205, 8'd204, 8'd0);
        send_pixel(8'hff, 8'h00, 8'haa);
        drain();

        // random phases with fresh settings, one without any idling
        for (int p = 0; p < PHASES; p++) begin
            write_all(pick_gamma(), pick_gamma(), pick_gamma(), 8'($urandom));
            no_idle = (p == 3);
            for (int i = 0; i < RANDOM_ITEMS / PHASES; i++)
                send_pixel(pick_level(), pick_level(), pick_level());
            drain();
        end
        no_idle = 0;

        if (!sb.failed) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
